FILE: src/intc_regs_pkg.sv
// Shared types and constants for the interrupt controller register block.
`timescale 1ns / 1ps

package intc_regs_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_LEVEL   = 3'd2,
        ACT_ENABLE  = 3'd3,
        ACT_DISABLE = 3'd4
    } act_t;

    // Update applied to one line register.
    typedef enum logic [2:0] {
        LOP_WRITE   = 3'd0,
        LOP_SET_ACT = 3'd1,
        LOP_CLR_ACT = 3'd2,
        LOP_SET_EN  = 3'd3,
        LOP_CLR_EN  = 3'd4
    } line_op_kind_t;

    typedef struct packed {
        logic          valid;
        line_op_kind_t kind;
        logic [7:0]    idx;
        logic [7:0]    data;
    } line_op_t;

    // Bit positions inside a line byte and the status word.
    localparam int unsigned BIT_ACTIVE    = 0;
    localparam int unsigned BIT_ENABLE    = 1;
    localparam int unsigned BIT_GLOBAL_EN = 0;

    localparam int unsigned READ_BYTES    = 8;

endpackage

FILE: src/intc_regs_lines.sv
// Per-line byte registers with a multi-byte read window and the pending OR.
`timescale 1ns / 1ps

module intc_regs_lines #(
    parameter int unsigned NUM_LINES = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  intc_regs_pkg::line_op_t   op,
    input  logic [7:0]                rd_base,
    input  logic [3:0]                rd_size,
    output logic [63:0]               rd_data,
    output logic                      pend_any_next
);

    localparam int unsigned IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    logic [7:0]       lines_reg  [NUM_LINES];
    logic [7:0]       lines_next [NUM_LINES];
    logic [IDX_W-1:0] op_idx;
    logic [8:0]       rd_idx     [intc_regs_pkg::READ_BYTES];

    assign op_idx = op.idx[IDX_W-1:0];

    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            lines_next[k] = lines_reg[k];
        end
        if (op.valid && ({1'b0, op.idx} < 9'(NUM_LINES))) begin
            case (op.kind)
                intc_regs_pkg::LOP_WRITE:   lines_next[op_idx] = op.data;
                intc_regs_pkg::LOP_SET_ACT:
                    lines_next[op_idx][intc_regs_pkg::BIT_ACTIVE] = 1'b1;
                intc_regs_pkg::LOP_CLR_ACT:
                    lines_next[op_idx][intc_regs_pkg::BIT_ACTIVE] = 1'b0;
                intc_regs_pkg::LOP_SET_EN:
                    lines_next[op_idx][intc_regs_pkg::BIT_ENABLE] = 1'b1;
                intc_regs_pkg::LOP_CLR_EN:
                    lines_next[op_idx][intc_regs_pkg::BIT_ENABLE] = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        pend_any_next = 1'b0;
        for (int k = 0; k < NUM_LINES; k++) begin
            pend_any_next = pend_any_next |
                (lines_next[k][intc_regs_pkg::BIT_ACTIVE] &
                 lines_next[k][intc_regs_pkg::BIT_ENABLE]);
        end
    end

    // A size above eight covers every byte lane, so no clamp is needed.
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < intc_regs_pkg::READ_BYTES; i++) begin
            rd_idx[i] = {1'b0, rd_base} + 9'(i);
            if ((4'(i) < rd_size) && (rd_idx[i] < 9'(NUM_LINES))) begin
                rd_data[8*i +: 8] = lines_reg[rd_idx[i][IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                lines_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_LINES; k++) begin
                lines_reg[k] <= lines_next[k];
            end
        end
    end

endmodule

FILE: src/interrupt_controller_regs_top.sv
// Top level of the interrupt controller register block.
`timescale 1ns / 1ps

// Interrupt controller registers: a 32-bit status word at offset 0 (bit 0 is
// the global enable) and one byte per line from LINE_REG_BASE upward (bit 0
// active, bit 1 enable). Each input beat is a bus read, a bus write or a line
// event and yields exactly one result beat carrying read data, the interrupt
// level after the beat, and an error flag for an out-of-range offset or line.
// One beat is taken every cycle while the output is not stalled. An accepted
// beat sits in the input register, and its result is loaded into the result
// register once that register is empty or being taken, and then shows on
// m_tdata. The result register lets the next beat enter while a result still
// waits. All line registers clear at reset in the same cycle.

module interrupt_controller_regs_top #(
    parameter int unsigned NUM_LINES     = 64,
    parameter int unsigned LINE_REG_BASE = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] offset, [11:8] access_size, [43:12] write_data,
    // [51:44] line_number, [52] level, [55:53] zero
    input  logic [55:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] read_data, [64] irq_line, [71:65] zero
    output logic [71:0] m_tdata,
    // [0] access_error
    output logic        m_tuser
);

    logic        in_valid_reg;
    logic [2:0]  act_reg;
    logic [7:0]  off_reg;
    logic [3:0]  size_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  lnum_reg;
    logic        lvl_reg;

    logic [31:0] gstat_reg;
    logic [31:0] gstat_next;

    logic        m_valid_reg;
    logic [63:0] m_rdata_reg;
    logic        m_irq_reg;
    logic        m_err_reg;

    logic        advance;
    logic        fire;
    logic        is_line_off;
    logic        line_ok;
    logic [7:0]  line_base;
    logic [63:0] rdata_next;
    logic        err_next;
    logic        irq_next;
    logic [63:0] lines_rd;
    logic        pend_any_next;
    intc_regs_pkg::line_op_t op;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign is_line_off = (off_reg >= 8'(LINE_REG_BASE)) &&
                         ({1'b0, off_reg} < 9'(NUM_LINES + LINE_REG_BASE));
    assign line_base   = off_reg - 8'(LINE_REG_BASE);
    assign line_ok     = {1'b0, lnum_reg} < 9'(NUM_LINES);

    always_comb begin
        op          = '0;
        op.kind     = intc_regs_pkg::LOP_WRITE;
        rdata_next  = '0;
        err_next    = 1'b0;
        gstat_next  = gstat_reg;
        case (act_reg)
            intc_regs_pkg::ACT_READ: begin
                if (off_reg == 8'd0) begin
                    rdata_next = {32'd0, gstat_reg};
                end else if (is_line_off) begin
                    rdata_next = lines_rd;
                end else begin
                    err_next = 1'b1;
                end
            end
            intc_regs_pkg::ACT_WRITE: begin
                if (off_reg == 8'd0) begin
                    gstat_next = wdata_reg;
                end else if (is_line_off) begin
                    op.valid = 1'b1;
                    op.kind  = intc_regs_pkg::LOP_WRITE;
                    op.idx   = line_base;
                    op.data  = wdata_reg[7:0];
                end else begin
                    err_next = 1'b1;
                end
            end
            intc_regs_pkg::ACT_LEVEL, intc_regs_pkg::ACT_ENABLE,
            intc_regs_pkg::ACT_DISABLE: begin
                if (line_ok) begin
                    op.valid = 1'b1;
                    op.idx   = lnum_reg;
                    if (act_reg == intc_regs_pkg::ACT_LEVEL) begin
                        op.kind = lvl_reg ? intc_regs_pkg::LOP_SET_ACT
                                          : intc_regs_pkg::LOP_CLR_ACT;
                    end else if (act_reg == intc_regs_pkg::ACT_ENABLE) begin
                        op.kind = intc_regs_pkg::LOP_SET_EN;
                    end else begin
                        op.kind = intc_regs_pkg::LOP_CLR_EN;
                    end
                end else begin
                    err_next = 1'b1;
                end
            end
            default: ;
        endcase
        // Commit state only when the beat moves on to the result register.
        op.valid = op.valid & fire;
        irq_next = gstat_next[intc_regs_pkg::BIT_GLOBAL_EN] & pend_any_next;
    end

    intc_regs_lines #(
        .NUM_LINES (NUM_LINES)
    ) u_lines (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .rd_base       (line_base),
        .rd_size       (size_reg),
        .rd_data       (lines_rd),
        .pend_any_next (pend_any_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg   <= s_tuser;
            off_reg   <= s_tdata[7:0];
            size_reg  <= s_tdata[11:8];
            wdata_reg <= s_tdata[43:12];
            lnum_reg  <= s_tdata[51:44];
            lvl_reg   <= s_tdata[52];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gstat_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                gstat_reg <= gstat_next;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_rdata_reg <= rdata_next;
            m_irq_reg   <= irq_next;
            m_err_reg   <= err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_irq_reg, m_rdata_reg};
    assign m_tuser  = m_err_reg;

endmodule
